// ===== design/tlik_pkg.sv =====
// Shared constants, tables and helpers for the leg inverse kinematics pipeline.
package tlik_pkg;

    localparam int ANGLE_FRAC_BITS = 6;

    localparam int ISQ_STEPS = 31;
    localparam int ISQ_W     = 2 * ISQ_STEPS;
    localparam int DIV_STEPS = 30;
    localparam int DIV_W     = 48;
    localparam int COR_STEPS = 20;
    localparam int COR_IN_W  = 32;
    localparam int COR_W     = COR_IN_W + 2;
    localparam int ANG_W     = 25;
    localparam int SUM_W     = 27;
    localparam int RND_W     = 40;
    localparam int NORM_TOP  = 29;
    localparam int NORM_STG  = 5;

    localparam longint DEG90_Q16 = 64'sd90 * 64'sd65536;

    localparam logic [1:0] REG_COXA  = 2'd0;
    localparam logic [1:0] REG_FEMUR = 2'd1;
    localparam logic [1:0] REG_TIBIA = 2'd2;

    localparam int ISQ_LAT = ISQ_STEPS;
    localparam int DIV_LAT = DIV_STEPS;
    localparam int COR_LAT = COR_STEPS + NORM_STG + 2;

    localparam int T_RHO  = 2 + ISQ_LAT;
    localparam int T_H    = T_RHO + 1;
    localparam int T_D2   = T_H + 2;
    localparam int T_D    = T_D2 + ISQ_LAT;
    localparam int T_NUM  = T_D + 1;
    localparam int T_CMP  = T_NUM + 1;
    localparam int T_Q    = T_CMP + DIV_LAT;
    localparam int T_C    = T_Q + 1;
    localparam int T_SRAD = T_C + 2;
    localparam int T_S    = T_SRAD + ISQ_LAT;
    localparam int T_Q2   = T_S + COR_LAT;
    localparam int T_SUM  = T_Q2 + 1;
    localparam int T_OUT  = T_SUM + 1;

    localparam int DLY_Z   = T_RHO;
    localparam int DLY_D2  = T_D - T_D2;
    localparam int DLY_SAT = DIV_LAT;
    localparam int DLY_C   = T_S - T_C;
    localparam int DLY_QC  = T_Q2 - COR_LAT;
    localparam int DLY_Q1  = T_Q2 - (T_H + COR_LAT);
    localparam int DLY_CLP = T_Q2 - T_CMP;

    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

    // fixed linkage angle, evaluated at elaboration
    function automatic longint calc_alpha();
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = 64'sd5582;
        y = 64'sd4858;
        z = 64'sd0;
        for (int k = 0; k < 32; k++) begin
            if (((x > y) ? x : y) < (64'sd1 <<< NORM_TOP)) begin
                x = x * 2;
                y = y * 2;
            end
        end
        for (int i = 0; i < COR_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(atan_q16(5'(i)));
            end
            else begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(atan_q16(5'(i)));
            end
        end
        return z;
    endfunction

    localparam longint ALPHA_Q16 = calc_alpha();

    function automatic logic signed [RND_W-1:0] round_ang(input logic signed [SUM_W-1:0] a);
        logic signed [RND_W-1:0] t;
        t = (RND_W'(a) <<< ANGLE_FRAC_BITS) + 40'sd32768;
        return t >>> 16;
    endfunction

endpackage

// ===== design/three_link_leg_inverse_kinematics.sv =====
// Top level: three-link leg inverse kinematics pipeline with APB link-length registers.
// Each accepted transaction yields its results with one done strobe.
// Throughput: one transaction per cycle; busy is tied low, set by the fully pipelined
// square root, divider and CORDIC chains (31, 30 and 27 stages).
// Results cannot be stalled by the receiver.
// Reset clears the valid line and restores link lengths (coxa 0, femur 1, tibia 1).
module three_link_leg_inverse_kinematics
    import tlik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] z_pos,
    output logic               done,
    output logic signed [14:0] coxa_angle,
    output logic signed [15:0] femur_angle,
    output logic signed [14:0] tibia_angle,
    output logic               reach_limited
);

    logic [13:0] hip_link_reg;
    logic [13:0] thigh_link_reg;
    logic [13:0] shank_link_reg;
    logic [27:0] ff_reg;
    logic [27:0] tt_reg;
    logic [27:0] ft_reg;

    logic vline_reg [T_OUT+1];

    logic signed [15:0] x0_reg;
    logic signed [15:0] y0_reg;
    logic signed [15:0] z0_reg;
    logic [31:0] xx_reg;
    logic [31:0] yy_reg;
    logic [31:0] r2_reg;
    logic [ISQ_STEPS-1:0] rho;
    logic signed [15:0] zd_reg [DLY_Z];
    logic signed [25:0] h_reg;
    logic signed [23:0] zq_reg;
    logic [47:0] hh_reg;
    logic [47:0] zz_reg;
    logic [47:0] d2_reg;
    logic [47:0] d2d_reg [DLY_D2];
    logic [ISQ_STEPS-1:0] droot;
    logic [37:0] fd_reg;
    logic signed [49:0] n1_reg;
    logic signed [49:0] n2_reg;
    logic [DIV_W-1:0] mag1_reg;
    logic [DIV_W-1:0] mag2_reg;
    logic [DIV_W-1:0] den1_reg;
    logic [DIV_W-1:0] den2_reg;
    logic sat1_reg;
    logic sat2_reg;
    logic neg1_reg;
    logic neg2_reg;
    logic clp_reg;
    logic [3:0] sd_reg [DLY_SAT];
    logic [DIV_STEPS-1:0] q1div;
    logic [DIV_STEPS-1:0] q2div;
    logic signed [31:0] c1_reg;
    logic signed [31:0] c2_reg;
    logic [30:0] m1_reg;
    logic [30:0] m2_reg;
    logic [60:0] mm1_reg;
    logic [60:0] mm2_reg;
    logic [60:0] sr1_reg;
    logic [60:0] sr2_reg;
    logic [ISQ_STEPS-1:0] s1root;
    logic [ISQ_STEPS-1:0] s2root;
    logic signed [31:0] c1d_reg [DLY_C];
    logic signed [31:0] c2d_reg [DLY_C];
    logic signed [ANG_W-1:0] qc_ang;
    logic signed [ANG_W-1:0] q1_ang;
    logic signed [ANG_W-1:0] q2a_ang;
    logic signed [ANG_W-1:0] q2b_ang;
    logic signed [ANG_W-1:0] qcd_reg [DLY_QC];
    logic signed [ANG_W-1:0] q1d_reg [DLY_Q1];
    logic clpd_reg [DLY_CLP];
    logic signed [SUM_W-1:0] coxa_s_reg;
    logic signed [SUM_W-1:0] femur_s_reg;
    logic signed [SUM_W-1:0] tibia_s_reg;
    logic clp_s_reg;

    logic signed [RND_W-1:0] coxa_r;
    logic signed [RND_W-1:0] femur_r;
    logic signed [RND_W-1:0] tibia_r;
    logic [49:0] mag1_w;
    logic [49:0] mag2_w;
    logic [DIV_W-1:0] den1_w;
    logic [DIV_W-1:0] den2_w;
    logic sat1_w;
    logic sat2_w;
    logic clp1_w;
    logic clp2_w;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hip_link_reg   <= 14'd0;
            thigh_link_reg <= 14'd1;
            shank_link_reg <= 14'd1;
        end
        else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_COXA:  hip_link_reg   <= pwdata[13:0];
                REG_FEMUR: thigh_link_reg <= pwdata[13:0];
                REG_TIBIA: shank_link_reg <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_COXA:  prdata = {18'd0, hip_link_reg};
            REG_FEMUR: prdata = {18'd0, thigh_link_reg};
            REG_TIBIA: prdata = {18'd0, shank_link_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ff_reg <= 28'(thigh_link_reg) * 28'(thigh_link_reg);
        tt_reg <= 28'(shank_link_reg) * 28'(shank_link_reg);
        ft_reg <= 28'(thigh_link_reg) * 28'(shank_link_reg);
    end

    // advance the valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i <= T_OUT; i++) begin
                vline_reg[i] <= 1'b0;
            end
        end
        else begin
            vline_reg[0] <= start && !busy;
            for (int i = 1; i <= T_OUT; i++) begin
                vline_reg[i] <= vline_reg[i-1];
            end
        end
    end

    assign done = vline_reg[T_OUT];

    // horizontal reach
    always_ff @(posedge clk)
    begin
        x0_reg <= x_pos;
        y0_reg <= y_pos;
        z0_reg <= z_pos;
        xx_reg <= 32'(32'(x0_reg) * 32'(x0_reg));
        yy_reg <= 32'(32'(y0_reg) * 32'(y0_reg));
        r2_reg <= xx_reg + yy_reg;
    end

    tlik_isqrt u_isqrt_rho
    (
        .clk  (clk),
        .n_in ({14'd0, r2_reg, 16'd0}),
        .root (rho)
    );

    tlik_cordic u_cordic_coxa
    (
        .clk (clk),
        .yv  (COR_IN_W'(x0_reg)),
        .xv  (COR_IN_W'(y0_reg)),
        .ang (qc_ang)
    );

    // reach relative to femur joint and squared distance
    always_ff @(posedge clk)
    begin
        h_reg  <= $signed({2'b00, rho[23:0]}) - $signed({4'b0000, hip_link_reg, 8'd0});
        zq_reg <= {zd_reg[DLY_Z-1], 8'd0};
        hh_reg <= 48'(h_reg * h_reg);
        zz_reg <= 48'(zq_reg * zq_reg);
        d2_reg <= hh_reg + zz_reg;
    end

    tlik_cordic u_cordic_reach
    (
        .clk (clk),
        .yv  (COR_IN_W'(h_reg)),
        .xv  (COR_IN_W'(zq_reg)),
        .ang (q1_ang)
    );

    tlik_isqrt u_isqrt_dist
    (
        .clk  (clk),
        .n_in ({14'd0, d2_reg}),
        .root (droot)
    );

    // law-of-cosines numerators and denominators
    always_ff @(posedge clk)
    begin
        fd_reg <= 38'(thigh_link_reg) * 38'(droot[23:0]);
        n1_reg <= $signed({6'd0, ff_reg, 16'd0}) - $signed({6'd0, tt_reg, 16'd0})
                  + $signed({2'd0, d2d_reg[DLY_D2-1]});
        n2_reg <= $signed({5'd0, 29'(ff_reg) + 29'(tt_reg), 16'd0})
                  - $signed({2'd0, d2d_reg[DLY_D2-1]});
    end

    assign den1_w = {1'b0, fd_reg, 9'd0};
    assign den2_w = {3'd0, ft_reg, 17'd0};
    assign mag1_w = n1_reg[49] ? 50'(-n1_reg) : n1_reg;
    assign mag2_w = n2_reg[49] ? 50'(-n2_reg) : n2_reg;
    assign sat1_w = (den1_w == '0) || (mag1_w >= {2'd0, den1_w});
    assign sat2_w = (den2_w == '0) || (mag2_w >= {2'd0, den2_w});
    assign clp1_w = (den1_w == '0) || (mag1_w > {2'd0, den1_w});
    assign clp2_w = (den2_w == '0) || (mag2_w > {2'd0, den2_w});

    always_ff @(posedge clk)
    begin
        mag1_reg <= mag1_w[DIV_W-1:0];
        mag2_reg <= mag2_w[DIV_W-1:0];
        den1_reg <= den1_w;
        den2_reg <= den2_w;
        sat1_reg <= sat1_w;
        sat2_reg <= sat2_w;
        neg1_reg <= n1_reg[49];
        neg2_reg <= n2_reg[49];
        clp_reg  <= clp1_w || clp2_w;
    end

    tlik_div u_div_c1
    (
        .clk (clk),
        .mag (mag1_reg),
        .den (den1_reg),
        .quo (q1div)
    );

    tlik_div u_div_c2
    (
        .clk (clk),
        .mag (mag2_reg),
        .den (den2_reg),
        .quo (q2div)
    );

    // clamp ratios, then sine term of acos
    always_ff @(posedge clk)
    begin
        if (sd_reg[DLY_SAT-1][0]) begin
            c1_reg <= sd_reg[DLY_SAT-1][1] ? -32'sh40000000 : 32'sh40000000;
            m1_reg <= 31'h40000000;
        end
        else begin
            c1_reg <= sd_reg[DLY_SAT-1][1] ? -$signed({2'b00, q1div}) : $signed({2'b00, q1div});
            m1_reg <= {1'b0, q1div};
        end
        if (sd_reg[DLY_SAT-1][2]) begin
            c2_reg <= sd_reg[DLY_SAT-1][3] ? -32'sh40000000 : 32'sh40000000;
            m2_reg <= 31'h40000000;
        end
        else begin
            c2_reg <= sd_reg[DLY_SAT-1][3] ? -$signed({2'b00, q2div}) : $signed({2'b00, q2div});
            m2_reg <= {1'b0, q2div};
        end
        mm1_reg <= 61'(62'(m1_reg) * 62'(m1_reg));
        mm2_reg <= 61'(62'(m2_reg) * 62'(m2_reg));
        sr1_reg <= (61'd1 << 60) - mm1_reg;
        sr2_reg <= (61'd1 << 60) - mm2_reg;
    end

    tlik_isqrt u_isqrt_s1
    (
        .clk  (clk),
        .n_in ({1'b0, sr1_reg}),
        .root (s1root)
    );

    tlik_isqrt u_isqrt_s2
    (
        .clk  (clk),
        .n_in ({1'b0, sr2_reg}),
        .root (s2root)
    );

    tlik_cordic u_cordic_acos1
    (
        .clk (clk),
        .yv  ({1'b0, s1root}),
        .xv  (c1d_reg[DLY_C-1]),
        .ang (q2a_ang)
    );

    tlik_cordic u_cordic_acos2
    (
        .clk (clk),
        .yv  ({1'b0, s2root}),
        .xv  (c2d_reg[DLY_C-1]),
        .ang (q2b_ang)
    );

    // hold side data until the later units catch up
    always_ff @(posedge clk)
    begin
        zd_reg[0]  <= z0_reg;
        d2d_reg[0] <= d2_reg;
        sd_reg[0]  <= {neg2_reg, sat2_reg, neg1_reg, sat1_reg};
        c1d_reg[0] <= c1_reg;
        c2d_reg[0] <= c2_reg;
        qcd_reg[0] <= qc_ang;
        q1d_reg[0] <= q1_ang;
        clpd_reg[0] <= clp_reg;
        for (int i = 1; i < DLY_Z; i++) begin
            zd_reg[i] <= zd_reg[i-1];
        end
        for (int i = 1; i < DLY_D2; i++) begin
            d2d_reg[i] <= d2d_reg[i-1];
        end
        for (int i = 1; i < DLY_SAT; i++) begin
            sd_reg[i] <= sd_reg[i-1];
        end
        for (int i = 1; i < DLY_C; i++) begin
            c1d_reg[i] <= c1d_reg[i-1];
            c2d_reg[i] <= c2d_reg[i-1];
        end
        for (int i = 1; i < DLY_QC; i++) begin
            qcd_reg[i] <= qcd_reg[i-1];
        end
        for (int i = 1; i < DLY_Q1; i++) begin
            q1d_reg[i] <= q1d_reg[i-1];
        end
        for (int i = 1; i < DLY_CLP; i++) begin
            clpd_reg[i] <= clpd_reg[i-1];
        end
    end

    // joint angle sums
    always_ff @(posedge clk)
    begin
        coxa_s_reg  <= -SUM_W'(qcd_reg[DLY_QC-1]);
        femur_s_reg <= SUM_W'(DEG90_Q16) - SUM_W'(q1d_reg[DLY_Q1-1]) - SUM_W'(q2a_ang)
                       + SUM_W'(ALPHA_Q16);
        tibia_s_reg <= SUM_W'(ALPHA_Q16) - SUM_W'(q2b_ang);
        clp_s_reg   <= clpd_reg[DLY_CLP-1];
    end

    assign coxa_r  = round_ang(coxa_s_reg);
    assign femur_r = round_ang(femur_s_reg);
    assign tibia_r = round_ang(tibia_s_reg);

    // round and saturate into the output fields
    always_ff @(posedge clk)
    begin
        if (coxa_r > 40'sd16383) begin
            coxa_angle <= 15'sd16383;
        end
        else if (coxa_r < -40'sd16384) begin
            coxa_angle <= -15'sd16384;
        end
        else begin
            coxa_angle <= coxa_r[14:0];
        end
        if (femur_r > 40'sd32767) begin
            femur_angle <= 16'sd32767;
        end
        else if (femur_r < -40'sd32768) begin
            femur_angle <= -16'sd32768;
        end
        else begin
            femur_angle <= femur_r[15:0];
        end
        if (tibia_r > 40'sd16383) begin
            tibia_angle <= 15'sd16383;
        end
        else if (tibia_r < -40'sd16384) begin
            tibia_angle <= -15'sd16384;
        end
        else begin
            tibia_angle <= tibia_r[14:0];
        end
        reach_limited <= clp_s_reg;
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(T_OUT+1) done)
        else $error("transaction result missing at expected latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(T_OUT+1) !done)
        else $error("result strobe without an accepted transaction");

endmodule

// ===== design/tlik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module tlik_isqrt
    import tlik_pkg::*;
(
    input  logic                 clk,
    input  logic [ISQ_W-1:0]     n_in,
    output logic [ISQ_STEPS-1:0] root
);

    logic [ISQ_W-1:0] n_reg [ISQ_STEPS];
    logic [ISQ_W-1:0] r_reg [ISQ_STEPS];
    logic [ISQ_W-1:0] n_next [ISQ_STEPS];
    logic [ISQ_W-1:0] r_next [ISQ_STEPS];

    always_comb
    begin
        logic [ISQ_W-1:0] pn;
        logic [ISQ_W-1:0] pr;
        logic [ISQ_W-1:0] b;
        logic [ISQ_W-1:0] t;
        for (int j = 0; j < ISQ_STEPS; j++) begin
            if (j == 0) begin
                pn = n_in;
                pr = '0;
            end
            else begin
                pn = n_reg[j-1];
                pr = r_reg[j-1];
            end
            b = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - j));
            t = pr + b;
            if (pn >= t) begin
                n_next[j] = pn - t;
                r_next[j] = (pr >> 1) + b;
            end
            else begin
                n_next[j] = pn;
                r_next[j] = pr >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < ISQ_STEPS; j++) begin
            n_reg[j] <= n_next[j];
            r_reg[j] <= r_next[j];
        end
    end

    assign root = r_reg[ISQ_STEPS-1][ISQ_STEPS-1:0];

endmodule

// ===== design/tlik_div.sv =====
// Pipelined restoring divider for fractions below one, one quotient bit per stage.
module tlik_div
    import tlik_pkg::*;
(
    input  logic                 clk,
    input  logic [DIV_W-1:0]     mag,
    input  logic [DIV_W-1:0]     den,
    output logic [DIV_STEPS-1:0] quo
);

    logic [DIV_W-1:0]     rem_reg [DIV_STEPS];
    logic [DIV_W-1:0]     den_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_reg [DIV_STEPS];
    logic [DIV_W-1:0]     rem_next [DIV_STEPS];
    logic [DIV_STEPS-1:0] q_next [DIV_STEPS];

    always_comb
    begin
        logic [DIV_W-1:0]     pr;
        logic [DIV_W-1:0]     pd;
        logic [DIV_STEPS-1:0] pq;
        logic [DIV_W:0]       t;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (j == 0) begin
                pr = mag;
                pd = den;
                pq = '0;
            end
            else begin
                pr = rem_reg[j-1];
                pd = den_reg[j-1];
                pq = q_reg[j-1];
            end
            t = {pr, 1'b0};
            if (t >= {1'b0, pd}) begin
                rem_next[j] = DIV_W'(t - {1'b0, pd});
                q_next[j]   = {pq[DIV_STEPS-2:0], 1'b1};
            end
            else begin
                rem_next[j] = t[DIV_W-1:0];
                q_next[j]   = {pq[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        for (int j = 0; j < DIV_STEPS; j++) begin
            rem_reg[j] <= rem_next[j];
            q_reg[j]   <= q_next[j];
        end
        for (int j = 1; j < DIV_STEPS; j++) begin
            den_reg[j] <= den_reg[j-1];
        end
    end

    assign quo = q_reg[DIV_STEPS-1];

endmodule

// ===== design/tlik_cordic.sv =====
// Pipelined vectoring CORDIC atan2 with magnitude normalization and quarter-turn pre-rotation.
module tlik_cordic
    import tlik_pkg::*;
(
    input  logic                       clk,
    input  logic signed [COR_IN_W-1:0] yv,
    input  logic signed [COR_IN_W-1:0] xv,
    output logic signed [ANG_W-1:0]    ang
);

    logic signed [COR_W-1:0] ax_reg;
    logic signed [COR_W-1:0] ay_reg;
    logic [COR_IN_W-1:0]     amx_reg;
    logic                    azero_reg;

    logic signed [COR_W-1:0] sx_reg [NORM_STG];
    logic signed [COR_W-1:0] sy_reg [NORM_STG];
    logic [COR_IN_W-1:0]     smx_reg [NORM_STG];
    logic                    szero_reg [NORM_STG];

    logic signed [COR_W-1:0] rx_reg;
    logic signed [COR_W-1:0] ry_reg;
    logic signed [ANG_W-1:0] rz_reg;
    logic                    rzero_reg;

    logic signed [COR_W-1:0] ix_reg [COR_STEPS];
    logic signed [COR_W-1:0] iy_reg [COR_STEPS];
    logic signed [ANG_W-1:0] iz_reg [COR_STEPS];
    logic                    izero_reg [COR_STEPS];

    logic signed [COR_W-1:0] ix_next [COR_STEPS];
    logic signed [COR_W-1:0] iy_next [COR_STEPS];
    logic signed [ANG_W-1:0] iz_next [COR_STEPS];

    logic [COR_IN_W-1:0] abs_x;
    logic [COR_IN_W-1:0] abs_y;

    assign abs_x = xv[COR_IN_W-1] ? COR_IN_W'(-xv) : xv;
    assign abs_y = yv[COR_IN_W-1] ? COR_IN_W'(-yv) : yv;

    always_ff @(posedge clk)
    begin
        ax_reg    <= {{2{xv[COR_IN_W-1]}}, xv};
        ay_reg    <= {{2{yv[COR_IN_W-1]}}, yv};
        amx_reg   <= (abs_y > abs_x) ? abs_y : abs_x;
        azero_reg <= (xv == '0) && (yv == '0);
    end

    // scale up until the larger magnitude reaches the normalization point
    always_ff @(posedge clk)
    begin
        logic signed [COR_W-1:0] px;
        logic signed [COR_W-1:0] py;
        logic [COR_IN_W-1:0]     pm;
        logic                    pz;
        int                      s;
        for (int j = 0; j < NORM_STG; j++) begin
            if (j == 0) begin
                px = ax_reg;
                py = ay_reg;
                pm = amx_reg;
                pz = azero_reg;
            end
            else begin
                px = sx_reg[j-1];
                py = sy_reg[j-1];
                pm = smx_reg[j-1];
                pz = szero_reg[j-1];
            end
            s = 16 >> j;
            if (pm < (COR_IN_W'(1) << (NORM_TOP + 1 - s))) begin
                sx_reg[j]  <= px <<< s;
                sy_reg[j]  <= py <<< s;
                smx_reg[j] <= pm << s;
            end
            else begin
                sx_reg[j]  <= px;
                sy_reg[j]  <= py;
                smx_reg[j] <= pm;
            end
            szero_reg[j] <= pz;
        end
    end

    always_ff @(posedge clk)
    begin
        rzero_reg <= szero_reg[NORM_STG-1];
        if (sx_reg[NORM_STG-1] < 0) begin
            if (sy_reg[NORM_STG-1] >= 0) begin
                rx_reg <= sy_reg[NORM_STG-1];
                ry_reg <= -sx_reg[NORM_STG-1];
                rz_reg <= ANG_W'(DEG90_Q16);
            end
            else begin
                rx_reg <= -sy_reg[NORM_STG-1];
                ry_reg <= sx_reg[NORM_STG-1];
                rz_reg <= ANG_W'(-DEG90_Q16);
            end
        end
        else begin
            rx_reg <= sx_reg[NORM_STG-1];
            ry_reg <= sy_reg[NORM_STG-1];
            rz_reg <= '0;
        end
    end

    always_comb
    begin
        logic signed [COR_W-1:0] px;
        logic signed [COR_W-1:0] py;
        logic signed [ANG_W-1:0] pa;
        logic signed [COR_W-1:0] dx;
        logic signed [COR_W-1:0] dy;
        for (int i = 0; i < COR_STEPS; i++) begin
            if (i == 0) begin
                px = rx_reg;
                py = ry_reg;
                pa = rz_reg;
            end
            else begin
                px = ix_reg[i-1];
                py = iy_reg[i-1];
                pa = iz_reg[i-1];
            end
            dx = py >>> i;
            dy = px >>> i;
            if (py > 0) begin
                ix_next[i] = px + dx;
                iy_next[i] = py - dy;
                iz_next[i] = pa + atan_q16(5'(i));
            end
            else begin
                ix_next[i] = px - dx;
                iy_next[i] = py + dy;
                iz_next[i] = pa - atan_q16(5'(i));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        izero_reg[0] <= rzero_reg;
        for (int i = 0; i < COR_STEPS; i++) begin
            ix_reg[i] <= ix_next[i];
            iy_reg[i] <= iy_next[i];
            iz_reg[i] <= iz_next[i];
        end
        for (int i = 1; i < COR_STEPS; i++) begin
            izero_reg[i] <= izero_reg[i-1];
        end
    end

    assign ang = izero_reg[COR_STEPS-1] ? '0 : iz_reg[COR_STEPS-1];

endmodule

// ===== sim/three_link_leg_inverse_kinematics_chk.sv =====
// Checker for the leg inverse kinematics block: predicts joint angles and compares results.
`timescale 1ns / 1ps
module three_link_leg_inverse_kinematics_chk
    import tlik_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] x_pos,
    input  logic signed [15:0] y_pos,
    input  logic signed [15:0] z_pos,
    input  logic               done,
    input  logic signed [14:0] coxa_angle,
    input  logic signed [15:0] femur_angle,
    input  logic signed [14:0] tibia_angle,
    input  logic               reach_limited,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic signed [14:0] coxa;
        logic signed [15:0] femur;
        logic signed [14:0] tibia;
        logic               limited;
    } joint_set_t;

    joint_set_t  joint_queue[$];
    logic [13:0] hip_link;
    logic [13:0] thigh_link;
    logic [13:0] shank_link;

    localparam longint CORDIC_TAB[COR_STEPS] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

    assign pending = joint_queue.size();

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint yv, longint xv);
        longint x;
        longint y;
        longint z;
        longint mx;
        longint t;
        longint dx;
        longint dy;
        x = xv;
        y = yv;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        mx = x < 0 ? -x : x;
        t = y < 0 ? -y : y;
        if (t > mx)
            mx = t;
        while (mx < (64'sd1 << 29))
        begin
            x *= 2;
            y *= 2;
            mx *= 2;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = DEG90_Q16;
            end
            else
            begin
                x = -y;
                y = t;
                z = -DEG90_Q16;
            end
        end
        for (int i = 0; i < COR_STEPS; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += CORDIC_TAB[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= CORDIC_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint clamped_ratio(longint num, longint unsigned den,
                                             inout logic lim);
        longint unsigned mag;
        longint unsigned q;
        longint unsigned rem;
        mag = num < 0 ? longint'(-num) : longint'(num);
        if (den == 0 || mag >= den)
        begin
            if (den == 0 || mag > den)
                lim = 1'b1;
            return num < 0 ? -(64'sd1 << 30) : (64'sd1 << 30);
        end
        q = 0;
        rem = mag;
        for (int i = 0; i < 30; i++)
        begin
            rem <<= 1;
            q <<= 1;
            if (rem >= den)
            begin
                rem -= den;
                q |= 1;
            end
        end
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint arc_cos(longint r);
        longint unsigned m;
        m = r < 0 ? -r : r;
        return vector_angle(int_sqrt((64'd1 << 60) - m * m), r);
    endfunction

    function automatic longint to_units(longint a, int bits);
        longint v;
        longint hi;
        v = floor_shift(a * (64'sd1 << ANGLE_FRAC_BITS) + 32768, 16);
        hi = (64'sd1 << (bits - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v;
    endfunction

    function automatic joint_set_t solve_leg(longint x, longint y, longint z);
        joint_set_t js;
        longint unsigned f;
        longint unsigned t;
        longint unsigned d2;
        longint unsigned d;
        longint rho;
        longint h;
        longint zq;
        longint num1;
        longint num2;
        longint c1;
        longint c2;
        longint alpha;
        logic lim;
        f = thigh_link;
        t = shank_link;
        lim = 1'b0;
        rho = int_sqrt(longint'(x * x + y * y) << 16);
        h = rho - (longint'(hip_link) << 8);
        zq = z * 256;
        d2 = h * h + zq * zq;
        d = int_sqrt(d2);
        num1 = longint'((f * f) << 16) - longint'((t * t) << 16) + longint'(d2);
        num2 = longint'((f * f + t * t) << 16) - longint'(d2);
        c1 = clamped_ratio(num1, 2 * f * d * 256, lim);
        c2 = clamped_ratio(num2, (2 * t * f) << 16, lim);
        alpha = vector_angle(4858, 5582);
        js.coxa = 15'(to_units(-vector_angle(x, y), 15));
        js.femur = 16'(to_units(-((vector_angle(h, zq) + arc_cos(c1)) - DEG90_Q16) + alpha, 16));
        js.tibia = 15'(to_units(-(arc_cos(c2) - DEG90_Q16) - (DEG90_Q16 - alpha), 15));
        js.limited = lim;
        return js;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        joint_set_t want;
        if (!rst_n)
        begin
            hip_link <= '0;
            thigh_link <= 14'd1;
            shank_link <= 14'd1;
            fail_count <= 0;
            joint_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_COXA:  hip_link <= pwdata[13:0];
                    REG_FEMUR: thigh_link <= pwdata[13:0];
                    REG_TIBIA: shank_link <= pwdata[13:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                joint_queue.push_back(solve_leg(x_pos, y_pos, z_pos));
            if (done)
            begin
                if (joint_queue.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result at %0t", $time);
                end
                else
                begin
                    want = joint_queue.pop_front();
                    if (want !== {coxa_angle, femur_angle, tibia_angle, reach_limited})
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                                want.coxa, want.femur, want.tibia, want.limited,
                                coxa_angle, femur_angle, tibia_angle, reach_limited);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/three_link_leg_inverse_kinematics_tb.sv =====
// Testbench top: drives foot positions and link lengths, reports the verdict.
`timescale 1ns / 1ps
module three_link_leg_inverse_kinematics_tb
    import tlik_pkg::*;
;

    localparam int LATENCY = 162;
    localparam int WATCHDOG = 5000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic signed [15:0] z_pos;
    logic               done;
    logic signed [14:0] coxa_angle;
    logic signed [15:0] femur_angle;
    logic signed [14:0] tibia_angle;
    logic               reach_limited;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    three_link_leg_inverse_kinematics u_dut (.*);

    three_link_leg_inverse_kinematics_chk u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("three_link_leg_inverse_kinematics_tb NOT OK");
            $finish;
        end
    end

    task automatic write_link(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_links(input logic [13:0] c, input logic [13:0] f, input logic [13:0] t);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        write_link(REG_COXA, {18'h3ffff, c});
        write_link(REG_FEMUR, {18'd0, f});
        write_link(REG_TIBIA, {18'd0, t});
    endtask

    task automatic send_foot(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        x_pos <= x;
        y_pos <= y;
        z_pos <= z;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic random_feet(input int count, input logic [13:0] f, input logic [13:0] t);
        int reach;
        for (int i = 0; i < count; i++)
        begin
            reach = int'(f) + int'(t);
            if ($urandom_range(0, 3) == 0 || reach > 8000)
                send_foot(16'($urandom), 16'($urandom), 16'($urandom));
            else
                send_foot(16'($urandom_range(0, 2 * reach) - reach),
                          16'($urandom_range(0, 2 * reach) - reach),
                          16'($urandom_range(0, 2 * reach) - reach));
        end
        start <= 1'b0;
    endtask

    initial
    begin
        logic [13:0] f;
        logic [13:0] t;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        x_pos = '0;
        y_pos = '0;
        z_pos = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_foot(16'sd100, 16'sd100, -16'sd50);
        start <= 1'b0;
        set_links(14'd520, 14'd1300, 14'd2100);
        send_foot(16'sd0, 16'sd0, 16'sd0);
        send_foot(-16'sd1000, 16'sd0, -16'sd1500);
        send_foot(16'sd0, -16'sd1000, 16'sd0);
        send_foot(16'sd32767, 16'sd32767, 16'sd32767);
        send_foot(-16'sd32768, -16'sd32768, -16'sd32768);
        send_foot(16'sd32767, -16'sd32768, 16'sd0);
        send_foot(16'sd0, 16'sd520, 16'sd0);
        send_foot(16'sd0, 16'sd520, -16'sd800);
        send_foot(16'sd0, 16'sd4000, -16'sd100);
        send_foot(16'sd1500, 16'sd2000, -16'sd1200);
        send_foot(-16'sd1, 16'sd0, 16'sd1);
        send_foot(16'sd0, 16'sd3920, 16'sd0);
        send_foot(16'sd0, 16'sd1320, 16'sd0);
        start <= 1'b0;
        set_links(14'd0, 14'd16383, 14'd16383);
        send_foot(16'sd0, 16'sd0, 16'sd0);
        send_foot(16'sd0, 16'sd32766, 16'sd0);
        send_foot(16'sd20000, 16'sd20000, -16'sd10000);
        start <= 1'b0;
        set_links(14'd16383, 14'd1, 14'd1);
        send_foot(16'sd0, 16'sd16383, 16'sd0);
        send_foot(16'sd0, 16'sd16384, 16'sd1);
        start <= 1'b0;

        for (int phase = 0; phase < 9; phase++)
        begin
            f = 14'($urandom_range(1, 3000));
            t = 14'($urandom_range(1, 3000));
            set_links(14'($urandom_range(0, 1000)), f, t);
            random_feet(60, f, t);
        end
        set_links(14'd16383, 14'd16383, 14'd16383);
        random_feet(15, 14'd16383, 14'd16383);

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_count == 0)
            $display("three_link_leg_inverse_kinematics_tb OK");
        else
            $display("three_link_leg_inverse_kinematics_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
design/tlik_pkg.sv
design/tlik_isqrt.sv
design/tlik_div.sv
design/tlik_cordic.sv
design/three_link_leg_inverse_kinematics.sv
sim/three_link_leg_inverse_kinematics_chk.sv
sim/three_link_leg_inverse_kinematics_tb.sv
